// ===== design/fpr_pkg.sv =====
// Shared types and constants for the frequency to performance request block.
// Used by fpr_regs and freq_to_perf_request; depends on nothing.
`default_nettype none

package fpr_pkg;

  localparam int KHZ_W      = 24;
  localparam int LEVEL_W    = 8;
  localparam int POINT_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int WORD_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // Offset divider: slope_num * nominal_point over slope_den.
  localparam int DIVA_DVD_W = LEVEL_W + POINT_W;
  localparam int DIVA_DVS_W = POINT_W;
  // Main divider: slope_num * target over slope_den * 1000.
  localparam int DIVB_DVD_W = LEVEL_W + KHZ_W;
  localparam int DIVB_DVS_W = POINT_W + 10;

  // Signed width of offset plus quotient.
  localparam int LVL_W = DIVB_DVD_W + 2;

  localparam logic [9:0]         KHZ_PER_MHZ = 10'd1000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_UNSUP = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_LOWEST    = 3'd0,
    REG_NONLINEAR = 3'd1,
    REG_NOMINAL   = 3'd2,
    REG_HIGHEST   = 3'd3,
    REG_LOW_PT    = 3'd4,
    REG_NOM_PT    = 3'd5,
    REG_MAX_SPEED = 3'd6,
    REG_EPP       = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] lowest;
    logic [LEVEL_W-1:0] nonlinear;
    logic [LEVEL_W-1:0] nominal;
    logic [LEVEL_W-1:0] highest;
    logic [POINT_W-1:0] low_pt;
    logic [POINT_W-1:0] nom_pt;
    logic [POINT_W-1:0] max_speed;
    logic [LEVEL_W-1:0] epp;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/fpr_regs.sv =====
// Configuration register file with an APB-style slave port.
// Depends on fpr_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module fpr_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [fpr_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [fpr_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [fpr_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready,
  output fpr_pkg::cfg_t                        cfg
);

  fpr_pkg::cfg_t     cfg_r;
  fpr_pkg::reg_idx_t idx;
  logic              wr;

  assign idx        = fpr_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      unique case (idx)
        fpr_pkg::REG_LOWEST:    cfg_r.lowest    <= cfg_pwdata[fpr_pkg::LEVEL_W-1:0];
        fpr_pkg::REG_NONLINEAR: cfg_r.nonlinear <= cfg_pwdata[fpr_pkg::LEVEL_W-1:0];
        fpr_pkg::REG_NOMINAL:   cfg_r.nominal   <= cfg_pwdata[fpr_pkg::LEVEL_W-1:0];
        fpr_pkg::REG_HIGHEST:   cfg_r.highest   <= cfg_pwdata[fpr_pkg::LEVEL_W-1:0];
        fpr_pkg::REG_LOW_PT:    cfg_r.low_pt    <= cfg_pwdata[fpr_pkg::POINT_W-1:0];
        fpr_pkg::REG_NOM_PT:    cfg_r.nom_pt    <= cfg_pwdata[fpr_pkg::POINT_W-1:0];
        fpr_pkg::REG_MAX_SPEED: cfg_r.max_speed <= cfg_pwdata[fpr_pkg::POINT_W-1:0];
        fpr_pkg::REG_EPP:       cfg_r.epp       <= cfg_pwdata[fpr_pkg::LEVEL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fpr_pkg::REG_LOWEST:    cfg_prdata = fpr_pkg::CFG_DATA_W'(cfg_r.lowest);
      fpr_pkg::REG_NONLINEAR: cfg_prdata = fpr_pkg::CFG_DATA_W'(cfg_r.nonlinear);
      fpr_pkg::REG_NOMINAL:   cfg_prdata = fpr_pkg::CFG_DATA_W'(cfg_r.nominal);
      fpr_pkg::REG_HIGHEST:   cfg_prdata = fpr_pkg::CFG_DATA_W'(cfg_r.highest);
      fpr_pkg::REG_LOW_PT:    cfg_prdata = fpr_pkg::CFG_DATA_W'(cfg_r.low_pt);
      fpr_pkg::REG_NOM_PT:    cfg_prdata = fpr_pkg::CFG_DATA_W'(cfg_r.nom_pt);
      fpr_pkg::REG_MAX_SPEED: cfg_prdata = fpr_pkg::CFG_DATA_W'(cfg_r.max_speed);
      fpr_pkg::REG_EPP:       cfg_prdata = fpr_pkg::CFG_DATA_W'(cfg_r.epp);
    endcase
  end

endmodule

`default_nettype wire

// ===== design/fpr_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Stand-alone; the top level hands down the widths from fpr_pkg.
`default_nettype none

module fpr_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   shifted, diff;
  logic             ge;

  assign busy     = (cnt_r != '0);
  assign quotient = q_r;

  always_comb begin
    shifted = {rem_r, q_r[DVD_W-1]};
    ge      = (shifted >= {1'b0, dvs_r});
    diff    = shifted - {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    q_nxt   = {q_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/freq_to_perf_request.sv =====
// Top level: maps a target frequency to a performance request word.
// Instantiates fpr_regs and two fpr_div units; depends on fpr_pkg.
//
// An input word is taken only when the block is idle, and its result is
// registered in steps: the MUL state forms the products, the DIV state
// starts the dividers, the 32-bit bit-serial divider then runs to the end,
// and the WAIT state forms the level and loads the output register. The
// shorter offset divider runs alongside it. A finished result may wait on
// out_stall while the next input word is already being worked on.
`default_nettype none

module freq_to_perf_request (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fpr_pkg::KHZ_W-1:0]       in_target_khz,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [fpr_pkg::STATUS_W-1:0]    out_status,
  output logic      [fpr_pkg::LEVEL_W-1:0]     out_desired_level,
  output logic      [fpr_pkg::WORD_W-1:0]      out_request_word,
  output logic                                 out_write_strobe,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [fpr_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [fpr_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [fpr_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int LVL_W = fpr_pkg::LVL_W;

  fpr_pkg::cfg_t   cfg;
  fpr_pkg::state_t state_r, state_nxt;

  logic [fpr_pkg::KHZ_W-1:0]      khz_r;
  logic [fpr_pkg::DIVA_DVD_W-1:0] prod_a_r;
  logic [fpr_pkg::DIVA_DVS_W-1:0] dvs_a_r;
  logic [fpr_pkg::DIVB_DVD_W-1:0] prod_b_r;
  logic [fpr_pkg::DIVB_DVS_W-1:0] dvs_b_r;
  logic                           anchored_r, unsup_r, zero_r;

  logic                           anchored;
  logic [fpr_pkg::LEVEL_W-1:0]    num;
  logic [fpr_pkg::POINT_W-1:0]    den;

  logic                           div_start, busy_a, busy_b;
  logic [fpr_pkg::DIVA_DVD_W-1:0] quot_a;
  logic [fpr_pkg::DIVB_DVD_W-1:0] quot_b;

  logic                           ld;
  logic [LVL_W-1:0]               lvl;
  logic                           lvl_sat, lvl_nonpos;
  fpr_pkg::status_t               res_status;
  logic [fpr_pkg::LEVEL_W-1:0]    res_level;
  logic [fpr_pkg::WORD_W-1:0]     res_word;
  logic                           res_strobe, res_update;

  logic                           out_valid_r;
  fpr_pkg::status_t               out_status_r;
  logic [fpr_pkg::LEVEL_W-1:0]    out_level_r;
  logic [fpr_pkg::WORD_W-1:0]     out_word_r;
  logic                           out_strobe_r;
  logic [fpr_pkg::WORD_W-1:0]     last_req_r;

  fpr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  fpr_div #(
    .DVD_W (fpr_pkg::DIVA_DVD_W),
    .DVS_W (fpr_pkg::DIVA_DVS_W)
  ) u_div_offset (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_a_r),
    .divisor  (dvs_a_r),
    .busy     (busy_a),
    .quotient (quot_a)
  );

  fpr_div #(
    .DVD_W (fpr_pkg::DIVB_DVD_W),
    .DVS_W (fpr_pkg::DIVB_DVS_W)
  ) u_div_level (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_b_r),
    .divisor  (dvs_b_r),
    .busy     (busy_b),
    .quotient (quot_b)
  );

  // Slope selection from the configuration.
  always_comb begin
    anchored = (cfg.low_pt != '0) && (cfg.nominal > cfg.lowest) &&
               (cfg.nom_pt > cfg.low_pt);
    num      = anchored ? (cfg.nominal - cfg.lowest) : cfg.highest;
    den      = anchored ? (cfg.nom_pt - cfg.low_pt) : cfg.max_speed;
  end

  assign ld = (state_r == fpr_pkg::ST_WAIT) && !busy_a && !busy_b &&
              (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    div_start = 1'b0;
    unique case (state_r)
      fpr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = fpr_pkg::ST_MUL;
        end
      end
      fpr_pkg::ST_MUL: begin
        state_nxt = fpr_pkg::ST_DIV;
      end
      fpr_pkg::ST_DIV: begin
        div_start = 1'b1;
        state_nxt = fpr_pkg::ST_WAIT;
      end
      fpr_pkg::ST_WAIT: begin
        if (ld) begin
          state_nxt = fpr_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == fpr_pkg::ST_IDLE && in_valid) begin
      khz_r <= in_target_khz;
    end
    if (state_r == fpr_pkg::ST_MUL) begin
      prod_a_r   <= fpr_pkg::DIVA_DVD_W'(num) * cfg.nom_pt;
      dvs_a_r    <= den;
      prod_b_r   <= fpr_pkg::DIVB_DVD_W'(num) * khz_r;
      dvs_b_r    <= fpr_pkg::DIVB_DVS_W'(den) * fpr_pkg::KHZ_PER_MHZ;
      anchored_r <= anchored;
      unsup_r    <= !anchored && (cfg.max_speed == '0);
      zero_r     <= (khz_r == '0);
    end
  end

  always_comb begin
    lvl = (anchored_r ? (LVL_W'(cfg.nominal) - LVL_W'(quot_a)) : '0) + LVL_W'(quot_b);
    lvl_nonpos = lvl[LVL_W-1] || (lvl == '0);
    lvl_sat    = !lvl[LVL_W-1] && (lvl > LVL_W'(fpr_pkg::LEVEL_MAX));
    res_status = fpr_pkg::STAT_OK;
    res_level  = '0;
    res_word   = last_req_r;
    res_strobe = 1'b0;
    res_update = 1'b0;
    priority if (zero_r) begin
      res_status = fpr_pkg::STAT_OK;
    end else if (unsup_r) begin
      res_status = fpr_pkg::STAT_UNSUP;
    end else if (lvl_nonpos) begin
      res_status = fpr_pkg::STAT_RANGE;
    end else begin
      res_level  = lvl_sat ? fpr_pkg::LEVEL_MAX : lvl[fpr_pkg::LEVEL_W-1:0];
      res_word   = {cfg.epp, res_level, cfg.nonlinear, cfg.highest};
      res_strobe = (res_word != last_req_r);
      res_update = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_req_r  <= '0;
    end else begin
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ld && res_update) begin
        last_req_r <= res_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_status_r <= res_status;
      out_level_r  <= res_level;
      out_word_r   <= res_word;
      out_strobe_r <= res_strobe;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_desired_level = out_level_r;
  assign out_request_word  = out_word_r;
  assign out_write_strobe  = out_strobe_r;

  a_word_tracks_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r == last_req_r))
    else $error("pending request word differs from the last request");

  a_strobe_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_strobe_r) |-> (out_status_r == fpr_pkg::STAT_OK))
    else $error("write strobe raised on a failed request");

  a_dividers_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpr_pkg::ST_DIV) |=> (busy_a && busy_b))
    else $error("dividers did not start");

endmodule

`default_nettype wire
